// ----- sv/sha1_hash_engine_macros.svh -----
// assertion macros for the sha-1 hash engine
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHA1E_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHA1E_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- sv/sha1e_pkg.sv -----
// shared types, constants and round functions for the sha-1 hash engine
package sha1e_pkg;

  localparam int WORD_BITS    = 32;
  localparam int DIGEST_WORDS = 5;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [0:DIGEST_WORDS-1][WORD_BITS-1:0] digest_t;

  localparam digest_t H_INIT = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                 32'h10325476, 32'hC3D2E1F0};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t PAD_MARK = 32'h80000000;

  function automatic word_t rotl(word_t x, logic [4:0] s);
    logic [2*WORD_BITS-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WORD_BITS-1:WORD_BITS];
  endfunction

  function automatic word_t round_f(logic [6:0] r, word_t b, word_t c, word_t d);
    word_t f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(logic [6:0] r);
    word_t k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ----- sv/sha1e_digest_out.sv -----
// digest output buffer: holds five digest words and streams them out
module sha1e_digest_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sha1e_pkg::digest_t words,
  output logic               digest_valid,
  input  logic               digest_ready,
  output sha1e_pkg::word_t   digest_word,
  output logic [2:0]         word_number,
  output logic               last_word
);
  import sha1e_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

  digest_t    dig;
  logic [2:0] ocnt;
  logic       busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ocnt <= '0;
    end else if (load) begin
      busy <= 1'b1;
      ocnt <= '0;
      dig  <= words;
    end else if (busy && digest_ready) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        dig[i] <= dig[i+1];
      end
      if (ocnt == LAST_IDX) begin
        busy <= 1'b0;
        ocnt <= '0;
      end else begin
        ocnt <= ocnt + 3'd1;
      end
    end
  end

  assign digest_valid = busy;
  assign digest_word  = dig[0];
  assign word_number  = ocnt;
  assign last_word    = (ocnt == LAST_IDX);

endmodule

// ----- sv/sha1_hash_engine.sv -----
// sha-1 hash engine top level: byte packing, block memory, round loop, padding
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   message  | msg_valid / msg_ready      | message_word, bytes_valid, end_of_message
//   digest   | digest_valid / digest_ready| digest_word, word_number, last_word
//
// a full 16-word block goes through one memory read setup, 80 rounds and one add
// the loop does one round per cycle; no request is taken while a block is hashed
// the final request adds up to 18 pad writes and one or two compressions
// digest words drain from their own buffer while the next message is taken
// block memory is not cleared after reset; every word is written before it is read
`include "sha1_hash_engine_macros.svh"

module sha1_hash_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_ready,
  input  sha1e_pkg::word_t message_word,
  input  logic [2:0]       bytes_valid,
  input  logic             end_of_message,
  output logic             digest_valid,
  input  logic             digest_ready,
  output sha1e_pkg::word_t digest_word,
  output logic [2:0]       word_number,
  output logic             last_word
);
  import sha1e_pkg::*;

  typedef enum logic [2:0] {
    IDLE, PREP, ROUND, ADD, MARK, ZERO, LENLO, DONE
  } state_t;

  state_t      state;
  digest_t     chain;
  word_t       va, vb, vc, vd, ve;
  word_t       sched [16];
  logic [6:0]  rnd;
  logic [4:0]  wcount;
  word_t       pend;
  logic [1:0]  pcnt;
  logic [63:0] bitcnt;
  logic        fin;
  logic        marked;
  logic        lendone;

  word_t       blk_mem [16];
  word_t       mem_rdata;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [3:0]  mem_raddr;
  word_t       mem_wdata;

  logic        accept;
  logic [2:0]  n_clamp;
  word_t       in_mask;
  logic [63:0] combined;
  logic [3:0]  total;
  logic        full;
  word_t       marker;
  word_t       w_cur;
  word_t       t_sum;
  logic        dig_load;

  assign msg_ready = (state == IDLE);
  assign accept    = msg_valid && msg_ready;

  // byte packing of pending bytes with the new request
  always_comb begin
    n_clamp  = (bytes_valid > 3'd4) ? 3'd4 : bytes_valid;
    in_mask  = ~(32'hFFFFFFFF >> {n_clamp, 3'b000});
    combined = {pend, 32'h0} | ({message_word & in_mask, 32'h0} >> {pcnt, 3'b000});
    total    = 4'(pcnt) + 4'(n_clamp);
    full     = (total >= 4'd4);
    marker   = pend | (PAD_MARK >> {pcnt, 3'b000});
  end

  // message schedule and round datapath
  always_comb begin
    if (rnd < 7'd16) begin
      w_cur = mem_rdata;
    end else begin
      w_cur = rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 5'd1);
    end
    t_sum = rotl(va, 5'd5) + round_f(rnd, vb, vc, vd) + ve + round_k(rnd) + w_cur;
  end

  // block memory ports
  always_comb begin
    mem_raddr = (state == ROUND) ? rnd[3:0] + 4'd1 : 4'd0;
    mem_waddr = wcount[3:0];
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state)
      IDLE: begin
        mem_we    = accept && full;
        mem_wdata = combined[63:32];
      end
      MARK: begin
        mem_we    = 1'b1;
        mem_wdata = marker;
      end
      ZERO: begin
        mem_we    = 1'b1;
        mem_wdata = (wcount == 5'd14) ? bitcnt[63:32] : '0;
      end
      LENLO: begin
        mem_we    = 1'b1;
        mem_wdata = bitcnt[31:0];
      end
      default: begin
        mem_we    = 1'b0;
        mem_wdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= blk_mem[mem_raddr];
  end

  assign dig_load = (state == DONE) && !digest_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      chain   <= H_INIT;
      rnd     <= '0;
      wcount  <= '0;
      pcnt    <= '0;
      pend    <= '0;
      bitcnt  <= '0;
      fin     <= 1'b0;
      marked  <= 1'b0;
      lendone <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            bitcnt <= bitcnt + 64'({n_clamp, 3'b000});
            fin    <= end_of_message;
            if (full) begin
              pend   <= combined[31:0];
              pcnt   <= 2'(total - 4'd4);
              wcount <= wcount + 5'd1;
            end else begin
              pend   <= combined[63:32];
              pcnt   <= 2'(total);
            end
            if (full && wcount == 5'd15) begin
              state <= PREP;
            end else if (end_of_message) begin
              state <= MARK;
            end
          end
        end
        PREP: begin
          rnd   <= '0;
          va    <= chain[0];
          vb    <= chain[1];
          vc    <= chain[2];
          vd    <= chain[3];
          ve    <= chain[4];
          state <= ROUND;
        end
        ROUND: begin
          for (int i = 0; i < 15; i++) begin
            sched[i] <= sched[i+1];
          end
          sched[15] <= w_cur;
          ve <= vd;
          vd <= vc;
          vc <= rotl(vb, 5'd30);
          vb <= va;
          va <= t_sum;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) begin
            state <= ADD;
          end
        end
        ADD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          wcount   <= '0;
          if (lendone) begin
            state <= DONE;
          end else if (fin && !marked) begin
            state <= MARK;
          end else if (fin) begin
            state <= ZERO;
          end else begin
            state <= IDLE;
          end
        end
        MARK: begin
          marked <= 1'b1;
          pend   <= '0;
          pcnt   <= '0;
          wcount <= wcount + 5'd1;
          state  <= (wcount == 5'd15) ? PREP : ZERO;
        end
        ZERO: begin
          wcount <= wcount + 5'd1;
          if (wcount == 5'd14) begin
            state <= LENLO;
          end else if (wcount == 5'd15) begin
            state <= PREP;
          end
        end
        LENLO: begin
          wcount  <= wcount + 5'd1;
          lendone <= 1'b1;
          state   <= PREP;
        end
        DONE: begin
          if (dig_load) begin
            chain   <= H_INIT;
            bitcnt  <= '0;
            wcount  <= '0;
            fin     <= 1'b0;
            marked  <= 1'b0;
            lendone <= 1'b0;
            state   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  sha1e_digest_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (dig_load),
    .words        (chain),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_number  (word_number),
    .last_word    (last_word)
  );

  `SHA1E_ASSERT_NEXT(a_round_end, state == ROUND && rnd == 7'd79, state == ADD, "round loop overran")
  `SHA1E_ASSERT_NOW(a_fill_bound, msg_ready, wcount < 5'd16, "block full while taking requests")
  `SHA1E_ASSERT_NEXT(a_block_full, accept && full && wcount == 5'd15, state == PREP, "full block not compressed")
  `SHA1E_ASSERT_NEXT(a_digest_hold, state == DONE && digest_valid, state == DONE, "digest overwritten while draining")

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the sha-1 hash engine: directed table, random messages, digest checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 450;
  localparam int HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 300;

  localparam sha1e_pkg::digest_t EMPTY_DIGEST = '{32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                                  32'h95601890, 32'hafd80709};
  localparam sha1e_pkg::digest_t ABC_DIGEST = '{32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                                32'h7850c26c, 32'h9cd0d89d};
  localparam sha1e_pkg::digest_t NO_DIGEST = '0;

  typedef struct {
    sha1e_pkg::word_t   word;
    logic [2:0]         nbytes;
    logic               eom;
    logic               known;
    sha1e_pkg::digest_t digest;
  } stim_row_t;

  typedef struct {
    sha1e_pkg::word_t word;
    logic [2:0]       num;
    logic             last;
  } digest_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             msg_valid = 1'b0;
  logic             msg_ready;
  sha1e_pkg::word_t message_word = '0;
  logic [2:0]       bytes_valid = '0;
  logic             end_of_message = 1'b0;
  logic             digest_valid;
  logic             digest_ready = 1'b0;
  sha1e_pkg::word_t digest_word;
  logic [2:0]       word_number;
  logic             last_word;

  sha1_hash_engine uut (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .message_word   (message_word),
    .bytes_valid    (bytes_valid),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word)
  );

  sha1e_pkg::word_t chain_h [5];
  logic [7:0]       block_bytes [64];
  int unsigned      fill_bytes;
  logic [63:0]      bit_len;

  digest_beat_t pending_digest [$];
  stim_row_t    dir_rows [$];

  int  errors = 0;
  int  n_checked = 0;
  int  n_req = 0;
  int  n_msgs = 0;
  int  max_len = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  logic holding = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding", cycles,
               pending_digest.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic sha1e_pkg::word_t rol(sha1e_pkg::word_t x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void compress_block();
    sha1e_pkg::word_t w [80];
    sha1e_pkg::word_t a, b, c, d, e, f, k, t;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 80; i++) begin
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = sha1e_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1e_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1e_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1e_pkg::K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void start_message();
    int i;
    for (i = 0; i < 5; i++) begin
      chain_h[i] = sha1e_pkg::H_INIT[i];
    end
    fill_bytes = 0;
    bit_len = '0;
  endfunction

  // absorb one accepted request; on end of message queue the five digest words
  function automatic void hash_request(sha1e_pkg::word_t word, logic [2:0] nb, logic eom,
                                       logic known, sha1e_pkg::digest_t typed);
    int unsigned n;
    int i;
    digest_beat_t beat;
    n = (nb > 3'd4) ? 4 : nb;
    for (i = 0; i < n; i++) begin
      block_bytes[fill_bytes] = word[31-8*i -: 8];
      fill_bytes++;
      if (fill_bytes == 64) begin
        compress_block();
        fill_bytes = 0;
      end
    end
    bit_len += 64'(n) * 64'd8;
    if (!eom) begin
      return;
    end
    block_bytes[fill_bytes] = 8'h80;
    fill_bytes++;
    if (fill_bytes > 56) begin
      while (fill_bytes < 64) begin
        block_bytes[fill_bytes] = 8'h00;
        fill_bytes++;
      end
      compress_block();
      fill_bytes = 0;
    end
    while (fill_bytes < 56) begin
      block_bytes[fill_bytes] = 8'h00;
      fill_bytes++;
    end
    for (i = 0; i < 8; i++) begin
      block_bytes[56+i] = bit_len[63-8*i -: 8];
    end
    compress_block();
    for (i = 0; i < 5; i++) begin
      beat.word = known ? typed[i] : chain_h[i];
      beat.num = 3'(i);
      beat.last = (i == 4);
      pending_digest.push_back(beat);
    end
    n_msgs++;
    start_message();
  endfunction

  task automatic send_request(input sha1e_pkg::word_t word, input logic [2:0] nb,
                              input logic eom, input logic known,
                              input sha1e_pkg::digest_t typed);
    while (!calm && $urandom_range(99) < 31) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    message_word <= word;
    bytes_valid <= nb;
    end_of_message <= eom;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    hash_request(word, nb, eom, known, typed);
    n_req++;
  endtask

  task automatic send_message(input int len);
    int left;
    int eff;
    int pick;
    logic [2:0] nb;
    bit done;
    left = len;
    done = 1'b0;
    if (len > max_len) begin
      max_len = len;
    end
    while (!done) begin
      if (left <= 4 && (left == 0 || $urandom_range(3) != 0)) begin
        nb = 3'(left);
        if (left == 4 && $urandom_range(1) == 1) begin
          nb = 3'($urandom_range(5, 7));
        end
        send_request($urandom(), nb, 1'b1, 1'b0, NO_DIGEST);
        done = 1'b1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          nb = 3'd4;
        end else if (pick < 90) begin
          nb = 3'($urandom_range(5, 7));
        end else begin
          nb = 3'($urandom_range(0, 3));
        end
        eff = (nb > 3'd4) ? 4 : nb;
        if (eff > left) begin
          nb = 3'(left);
          eff = left;
        end
        send_request($urandom(), nb, 1'b0, 1'b0, NO_DIGEST);
        left -= eff;
      end
    end
  endtask

  function automatic int pick_length();
    int p;
    p = $urandom_range(99);
    if (p < 55) begin
      return $urandom_range(0, 40);
    end else if (p < 70) begin
      return $urandom_range(52, 68);
    end else if (p < 80) begin
      return $urandom_range(116, 132);
    end else if (p < 97) begin
      return $urandom_range(60, 200);
    end
    return $urandom_range(300, 500);
  endfunction

  // output side: random backpressure plus one long hold-off
  always @(posedge clk) begin
    digest_beat_t beat;
    if (rst) begin
      digest_ready <= 1'b0;
    end else begin
      if (digest_valid && digest_ready) begin
        if (pending_digest.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected digest word %h number %0d last %b", digest_word,
                     word_number, last_word);
          end
        end else begin
          beat = pending_digest.pop_front();
          n_checked++;
          if (digest_word !== beat.word || word_number !== beat.num ||
              last_word !== beat.last) begin
            errors++;
            if (errors <= 10) begin
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b", beat.word,
                       beat.num, beat.last, digest_word, word_number, last_word);
            end
          end
        end
      end
      digest_ready <= !holding && (calm || $urandom_range(99) >= 31);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin
    int r;
    int start_req;
    start_message();
    for (r = 0; r < 64; r++) begin
      block_bytes[r] = 8'h00;
    end

    // empty message, "abc" whole and in pieces, oversized byte counts, 56-byte message
    dir_rows.push_back('{32'hffffffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST});
    dir_rows.push_back('{32'h616263a5, 3'd3, 1'b1, 1'b1, ABC_DIGEST});
    dir_rows.push_back('{32'h61ffffff, 3'd1, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h62630000, 3'd2, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'hdeadbeef, 3'd0, 1'b1, 1'b1, ABC_DIGEST});
    dir_rows.push_back('{32'hffffffff, 3'd7, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h00000000, 3'd5, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h12345678, 3'd6, 1'b1, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h00000000, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'hffffffff, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h80000000, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h00000001, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h7fffffff, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'hfffffffe, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'haaaaaaaa, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h55555555, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h01234567, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h89abcdef, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'hfedcba98, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h76543210, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'h0f0f0f0f, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'hf0f0f0f0, 3'd4, 1'b0, 1'b0, NO_DIGEST});
    dir_rows.push_back('{32'hcafef00d, 3'd0, 1'b1, 1'b0, NO_DIGEST});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].word, dir_rows[i].nbytes, dir_rows[i].eom, dir_rows[i].known,
                   dir_rows[i].digest);
    end

    // let the directed digests drain before the random part
    msg_valid <= 1'b0;
    wait (pending_digest.size() == 0);
    @(posedge clk);

    // short messages against a stalled output so the engine backs up
    hold_req = 1'b1;
    for (r = 0; r < 12; r++) begin
      send_message($urandom_range(0, 8));
    end

    start_req = n_req;
    while (n_req - start_req < RANDOM_REQS) begin
      calm = (n_req - start_req >= 200 && n_req - start_req < 320);
      send_message(pick_length());
    end
    calm = 1'b0;

    msg_valid <= 1'b0;
    wait (pending_digest.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests in %0d messages, %0d digest words checked, %0d errors", n_req,
             n_msgs, n_checked, errors);
    $display("longest message %0d bytes, output hold-off of %0d cycles, %0d cycles run",
             max_len, HOLD_CYCLES, cycles);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
